/* rtl/core/tfn_pkg.sv */
// ============================================================================
// tfn_pkg: shared constants for the triangle face normal unit
// Fixed widths of the normalized vector, its squared length and its root.
// ============================================================================
`default_nettype none

package tfn_pkg;

    // Width of a component after normalizing the largest one to its top bit
    localparam int A_W     = 31;
    // Width of one squared component
    localparam int SQ_W    = 2 * A_W;
    // Width of the sum of three squares
    localparam int SUM_W   = SQ_W + 2;
    // Width of the integer square root of that sum
    localparam int ROOT_W  = SUM_W / 2;
    // Chunk width of the leading-one search
    localparam int CHUNK_W = 8;

endpackage

`default_nettype wire

/* rtl/core/triangle_face_normal_unit.sv */
// Throughput: one triangle per cycle while the output is not stalled; every stage holds its own valid bit.
// The square root (one bit per stage) and the divider (one quotient bit per stage)
// set the depth. A stalled output holds only the stages that are full.
// Reset is synchronous and active low and clears all valid bits; data is not reset.
// ============================================================================
// triangle_face_normal_unit: unit face normal of a triangle
// Edges, exact cross product, normalization to Q1.NORMAL_FRAC_BITS.
// ============================================================================
`default_nettype none

module triangle_face_normal_unit #(
    parameter int COORD_WIDTH      = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_WIDTH-1:0]       i_first_x,
    input  logic signed [COORD_WIDTH-1:0]       i_first_y,
    input  logic signed [COORD_WIDTH-1:0]       i_first_z,
    input  logic signed [COORD_WIDTH-1:0]       i_second_x,
    input  logic signed [COORD_WIDTH-1:0]       i_second_y,
    input  logic signed [COORD_WIDTH-1:0]       i_second_z,
    input  logic signed [COORD_WIDTH-1:0]       i_third_x,
    input  logic signed [COORD_WIDTH-1:0]       i_third_y,
    input  logic signed [COORD_WIDTH-1:0]       i_third_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_normal_z,
    output logic                                o_degenerate
);

    localparam int CW = COORD_WIDTH;
    localparam int F  = NORMAL_FRAC_BITS;
    localparam int XW = 2 * CW + 3;
    localparam int OW = F + 2;
    localparam logic signed [OW-1:0] NMAX = OW'(1) << F;

    logic [CW-1:0]                  coord [9];
    logic                           x_valid, x_stall;
    logic signed [XW-1:0]           x_cross [3];
    logic                           m_valid, m_stall;
    logic [tfn_pkg::A_W-1:0]        m_a [3];
    logic                           m_neg [3];
    logic [tfn_pkg::SUM_W-1:0]      m_sum;
    logic                           m_degen;
    logic                           s_valid, s_stall;
    logic [tfn_pkg::A_W-1:0]        s_a [3];
    logic                           s_neg [3];
    logic [tfn_pkg::ROOT_W-1:0]     s_root;
    logic                           s_degen;
    logic signed [OW-1:0]           normal [3];

    // Gather the vertex coordinates
    assign coord[0] = i_first_x;
    assign coord[1] = i_first_y;
    assign coord[2] = i_first_z;
    assign coord[3] = i_second_x;
    assign coord[4] = i_second_y;
    assign coord[5] = i_second_z;
    assign coord[6] = i_third_x;
    assign coord[7] = i_third_y;
    assign coord[8] = i_third_z;

    tfn_cross #(.CW(CW)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_coord (coord),
        .o_valid (x_valid),
        .i_stall (x_stall),
        .o_cross (x_cross)
    );

    tfn_norm #(.CW(CW)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (x_valid),
        .o_stall (x_stall),
        .i_cross (x_cross),
        .o_valid (m_valid),
        .i_stall (m_stall),
        .o_a     (m_a),
        .o_neg   (m_neg),
        .o_sum   (m_sum),
        .o_degen (m_degen)
    );

    tfn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_valid),
        .o_stall (m_stall),
        .i_a     (m_a),
        .i_neg   (m_neg),
        .i_sum   (m_sum),
        .i_degen (m_degen),
        .o_valid (s_valid),
        .i_stall (s_stall),
        .o_a     (s_a),
        .o_neg   (s_neg),
        .o_root  (s_root),
        .o_degen (s_degen)
    );

    tfn_div #(.F(F)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_valid),
        .o_stall  (s_stall),
        .i_a      (s_a),
        .i_neg    (s_neg),
        .i_root   (s_root),
        .i_degen  (s_degen),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_normal (normal),
        .o_degen  (o_degenerate)
    );

    assign o_normal_x = normal[0];
    assign o_normal_y = normal[1];
    assign o_normal_z = normal[2];

    // A free output lets every stage advance
    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |->
            o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0)
        else $error("degenerate result with nonzero normal");

    a_nondegen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |->
            o_normal_x != '0 || o_normal_y != '0 || o_normal_z != '0)
        else $error("zero normal without degenerate flag");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_normal_x <= NMAX && o_normal_x >= -NMAX
                 && o_normal_y <= NMAX && o_normal_y >= -NMAX
                 && o_normal_z <= NMAX && o_normal_z >= -NMAX)
        else $error("normal component out of unit range");

endmodule

`default_nettype wire

/* rtl/core/tfn_cross.sv */
// ============================================================================
// tfn_cross: edge vectors and exact cross product
// Three stages: edge subtraction, six products, product differences.
// ============================================================================
`default_nettype none

module tfn_cross #(
    parameter int CW = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [CW-1:0]          i_coord [9],
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [2*CW+2:0] o_cross [3]
);

    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int XW = PW + 1;
    localparam int NS = 3;

    logic [NS-1:0]          r_v;
    logic [NS:0]            ready;
    logic signed [EW-1:0]   r_eu [3];
    logic signed [EW-1:0]   r_ew [3];
    logic signed [PW-1:0]   r_p  [6];
    logic signed [XW-1:0]   r_c  [3];

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        ready[NS] = !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            ready[k] = !r_v[k] || ready[k+1];
        end
    end

    // Move valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ready[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (ready[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Form edges, products and cross terms
    always_ff @(posedge i_clk) begin
        if (ready[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_eu[i] <= $signed({i_coord[3+i][CW-1], i_coord[3+i]})
                         - $signed({i_coord[i][CW-1], i_coord[i]});
                r_ew[i] <= $signed({i_coord[6+i][CW-1], i_coord[6+i]})
                         - $signed({i_coord[i][CW-1], i_coord[i]});
            end
        end
        if (ready[1]) begin
            r_p[0] <= r_eu[1] * r_ew[2];
            r_p[1] <= r_eu[2] * r_ew[1];
            r_p[2] <= r_eu[2] * r_ew[0];
            r_p[3] <= r_eu[0] * r_ew[2];
            r_p[4] <= r_eu[0] * r_ew[1];
            r_p[5] <= r_eu[1] * r_ew[0];
        end
        if (ready[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= {r_p[2*i][PW-1], r_p[2*i]} - {r_p[2*i+1][PW-1], r_p[2*i+1]};
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_cross[i] = r_c[i];
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_stall = !ready[0];

endmodule

`default_nettype wire

/* rtl/core/tfn_norm.sv */
// ============================================================================
// tfn_norm: magnitude, leading-one search, scaling and sum of squares
// Six stages bring the largest component to its top bit and square all three.
// ============================================================================
`default_nettype none

module tfn_norm #(
    parameter int CW = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [2*CW+2:0]       i_cross [3],
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [tfn_pkg::A_W-1:0]      o_a [3],
    output logic                         o_neg [3],
    output logic [tfn_pkg::SUM_W-1:0]    o_sum,
    output logic                         o_degen
);

    localparam int XW  = 2 * CW + 3;
    localparam int CHW = tfn_pkg::CHUNK_W;
    localparam int NCH = (XW + CHW - 1) / CHW;
    localparam int LW  = $clog2(CHW);
    localparam int TW  = $clog2(XW + 1);
    localparam int AW  = tfn_pkg::A_W;
    localparam int NS  = 6;

    logic [NS-1:0]               r_v;
    logic [NS:0]                 ready;
    logic                        r_neg [NS][3];
    logic [XW-1:0]               r_m0 [3];
    logic [XW-1:0]               r_m1 [3];
    logic [XW-1:0]               r_m2 [3];
    logic                        r_nz [NCH];
    logic [LW-1:0]               r_lo [NCH];
    logic [TW-1:0]               r_top;
    logic [AW-1:0]               r_a3 [3];
    logic [AW-1:0]               r_a4 [3];
    logic [AW-1:0]               r_a5 [3];
    logic [tfn_pkg::SQ_W-1:0]    r_sq [3];
    logic [tfn_pkg::SUM_W-1:0]   r_sum;
    logic                        r_dg3;
    logic                        r_dg4;
    logic                        r_dg5;
    logic [NCH*CHW-1:0]          orv;
    logic [TW-1:0]               top_c;
    logic [XW+AW-1:0]            sh [3];

    function automatic logic [LW-1:0] msb_idx(input logic [CHW-1:0] x);
        logic [LW-1:0] idx;
        idx = '0;
        for (int b = 0; b < CHW; b++) begin
            if (x[b]) idx = LW'(b);
        end
        return idx;
    endfunction

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        ready[NS] = !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            ready[k] = !r_v[k] || ready[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ready[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (ready[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Merge all magnitudes for the leading-one search
    assign orv = (NCH*CHW)'(r_m0[0] | r_m0[1] | r_m0[2]);

    // Pick the highest nonzero chunk
    always_comb begin
        top_c = '0;
        for (int j = 0; j < NCH; j++) begin
            if (r_nz[j]) top_c = TW'(j * CHW) + TW'(r_lo[j]) + TW'(1);
        end
    end

    // Shift so that the largest magnitude fills exactly the top bit
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sh[i] = {r_m2[i], {AW{1'b0}}} >> r_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_m0[i]     <= i_cross[i][XW-1] ? (~i_cross[i] + XW'(1)) : i_cross[i];
                r_neg[0][i] <= i_cross[i][XW-1];
            end
        end
        for (int k = 1; k < NS; k++) begin
            if (ready[k]) begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[k][i] <= r_neg[k-1][i];
                end
            end
        end
        if (ready[1]) begin
            for (int i = 0; i < 3; i++) r_m1[i] <= r_m0[i];
            for (int j = 0; j < NCH; j++) begin
                r_nz[j] <= |orv[j*CHW +: CHW];
                r_lo[j] <= msb_idx(orv[j*CHW +: CHW]);
            end
        end
        if (ready[2]) begin
            for (int i = 0; i < 3; i++) r_m2[i] <= r_m1[i];
            r_top <= top_c;
        end
        if (ready[3]) begin
            for (int i = 0; i < 3; i++) r_a3[i] <= sh[i][AW-1:0];
            r_dg3 <= (r_top == '0);
        end
        if (ready[4]) begin
            for (int i = 0; i < 3; i++) begin
                r_a4[i] <= r_a3[i];
                r_sq[i] <= r_a3[i] * r_a3[i];
            end
            r_dg4 <= r_dg3;
        end
        if (ready[5]) begin
            for (int i = 0; i < 3; i++) r_a5[i] <= r_a4[i];
            r_sum <= tfn_pkg::SUM_W'(r_sq[0]) + tfn_pkg::SUM_W'(r_sq[1])
                   + tfn_pkg::SUM_W'(r_sq[2]);
            r_dg5 <= r_dg4;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_a[i]   = r_a5[i];
            o_neg[i] = r_neg[NS-1][i];
        end
    end

    assign o_sum   = r_sum;
    assign o_degen = r_dg5;
    assign o_valid = r_v[NS-1];
    assign o_stall = !ready[0];

endmodule

`default_nettype wire

/* rtl/core/tfn_sqrt.sv */
// ============================================================================
// tfn_sqrt: pipelined integer square root
// One root bit per stage, from the top bit down, on a running remainder.
// ============================================================================
`default_nettype none

module tfn_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tfn_pkg::A_W-1:0]       i_a [3],
    input  logic                          i_neg [3],
    input  logic [tfn_pkg::SUM_W-1:0]     i_sum,
    input  logic                          i_degen,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tfn_pkg::A_W-1:0]       o_a [3],
    output logic                          o_neg [3],
    output logic [tfn_pkg::ROOT_W-1:0]    o_root,
    output logic                          o_degen
);

    localparam int NS = tfn_pkg::ROOT_W;
    localparam int SW = tfn_pkg::SUM_W;
    localparam int RW = tfn_pkg::ROOT_W;
    localparam int AW = tfn_pkg::A_W;

    logic [NS-1:0]   r_v;
    logic [NS:0]     ready;
    logic [SW-1:0]   r_rem  [NS];
    logic [RW-1:0]   r_root [NS];
    logic [AW-1:0]   r_a    [NS][3];
    logic            r_neg  [NS][3];
    logic            r_dg   [NS];
    logic [SW-1:0]   n_rem  [NS];
    logic [RW-1:0]   n_root [NS];

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        ready[NS] = !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            ready[k] = !r_v[k] || ready[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ready[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (ready[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Try one root bit per stage
    for (genvar k = 0; k < NS; k++) begin : g_bit
        localparam int B = NS - 1 - k;
        logic [SW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [SW+1:0] trial;
        logic          take;
        if (k == 0) begin : g_first
            assign rem_in  = i_sum;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end
        assign trial     = ((SW+2)'(root_in) << (B + 1)) | ((SW+2)'(1) << (2 * B));
        assign take      = (SW+2)'(rem_in) >= trial;
        assign n_rem[k]  = take ? SW'((SW+2)'(rem_in) - trial) : rem_in;
        assign n_root[k] = take ? (root_in | (RW'(1) << B)) : root_in;
    end

    always_ff @(posedge i_clk) begin
        if (ready[0]) begin
            r_rem[0]  <= n_rem[0];
            r_root[0] <= n_root[0];
            r_dg[0]   <= i_degen;
            for (int i = 0; i < 3; i++) begin
                r_a[0][i]   <= i_a[i];
                r_neg[0][i] <= i_neg[i];
            end
        end
        for (int k = 1; k < NS; k++) begin
            if (ready[k]) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_dg[k]   <= r_dg[k-1];
                for (int i = 0; i < 3; i++) begin
                    r_a[k][i]   <= r_a[k-1][i];
                    r_neg[k][i] <= r_neg[k-1][i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_a[i]   = r_a[NS-1][i];
            o_neg[i] = r_neg[NS-1][i];
        end
    end

    assign o_root  = r_root[NS-1];
    assign o_degen = r_dg[NS-1];
    assign o_valid = r_v[NS-1];
    assign o_stall = !ready[0];

endmodule

`default_nettype wire

/* rtl/core/tfn_div.sv */
// ============================================================================
// tfn_div: rounded division by the length and sign restore
// One quotient bit per stage in three lanes, then sign and degenerate select.
// ============================================================================
`default_nettype none

module tfn_div #(
    parameter int F = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tfn_pkg::A_W-1:0]       i_a [3],
    input  logic                          i_neg [3],
    input  logic [tfn_pkg::ROOT_W-1:0]    i_root,
    input  logic                          i_degen,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [F+1:0]           o_normal [3],
    output logic                          o_degen
);

    localparam int AW = tfn_pkg::A_W;
    localparam int RW = tfn_pkg::ROOT_W;
    localparam int QW = F + 1;
    localparam int OW = F + 2;
    localparam int NW = AW + F + 1;
    localparam int NS = QW + 2;
    localparam int ND = QW + 1;

    logic [NS-1:0]          r_v;
    logic [NS:0]            ready;
    logic [RW-1:0]          r_r   [ND][3];
    logic [QW-1:0]          r_n   [ND][3];
    logic [QW-1:0]          r_q   [ND][3];
    logic [RW-1:0]          r_l   [ND];
    logic                   r_neg [NS][3];
    logic                   r_dg  [NS];
    logic signed [OW-1:0]   r_out [3];
    logic [NW-1:0]          num   [3];
    logic [RW-1:0]          n_r   [ND][3];
    logic [QW-1:0]          n_q   [ND][3];

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        ready[NS] = !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            ready[k] = !r_v[k] || ready[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ready[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (ready[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Add half the length for round to nearest
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = NW'({i_a[i], {F{1'b0}}}) + NW'(i_root >> 1);
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 1; j < ND; j++) begin : g_step
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [RW:0] t;
            logic        take;
            assign t         = {r_r[j-1][l], r_n[j-1][l][QW-1]};
            assign take      = t >= {1'b0, r_l[j-1]};
            assign n_r[j][l] = take ? RW'(t - {1'b0, r_l[j-1]}) : t[RW-1:0];
            assign n_q[j][l] = {r_q[j-1][l][QW-2:0], take};
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_init
        assign n_r[0][l] = RW'(num[l][NW-1:QW]);
        assign n_q[0][l] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (ready[0]) begin
            r_l[0]  <= i_root;
            r_dg[0] <= i_degen;
            for (int i = 0; i < 3; i++) begin
                r_r[0][i]   <= n_r[0][i];
                r_n[0][i]   <= num[i][QW-1:0];
                r_q[0][i]   <= n_q[0][i];
                r_neg[0][i] <= i_neg[i];
            end
        end
        for (int k = 1; k < ND; k++) begin
            if (ready[k]) begin
                r_l[k] <= r_l[k-1];
                for (int i = 0; i < 3; i++) begin
                    r_r[k][i] <= n_r[k][i];
                    r_n[k][i] <= r_n[k-1][i] << 1;
                    r_q[k][i] <= n_q[k][i];
                end
            end
        end
        for (int k = 1; k < NS; k++) begin
            if (ready[k]) begin
                r_dg[k] <= r_dg[k-1];
                for (int i = 0; i < 3; i++) begin
                    r_neg[k][i] <= r_neg[k-1][i];
                end
            end
        end
        // Apply sign, force zero on a degenerate triangle
        if (ready[NS-1]) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dg[NS-2]) begin
                    r_out[i] <= '0;
                end else if (r_neg[NS-2][i]) begin
                    r_out[i] <= OW'(0) - OW'(r_q[ND-1][i]);
                end else begin
                    r_out[i] <= OW'(r_q[ND-1][i]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_normal[i] = r_out[i];
        end
    end

    assign o_degen = r_dg[NS-1];
    assign o_valid = r_v[NS-1];
    assign o_stall = !ready[0];

endmodule

`default_nettype wire
